// File: design/qsbs_pkg.sv
package qsbs_pkg;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic               last_coefficient;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] codeword;
        logic [5:0]         coef_index;
        logic [30:0]        final_step;
        logic [6:0]         nonzero_count;
        logic [11:0]        total_bits;
        logic [6:0]         passes_used;
        logic               within_tolerance;
        logic               last_codeword;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MAX,
        ST_PASS_START,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BITS,
        ST_DECIDE,
        ST_EMIT_START,
        ST_EMIT_DIV,
        ST_EMIT_OUT
    } state_t;

    localparam int unsigned REG_TARGET    = 0;
    localparam int unsigned REG_TOLERANCE = 1;
    localparam int unsigned REG_MAX_ITER  = 2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 22;

    // divider handshake between the sequencer and the shared divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// File: design/qsbs_ram.sv
module qsbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/qsbs_div.sv
module qsbs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  qsbs_pkg::div_req_t  req,
    output qsbs_pkg::div_rsp_t  rsp
);
    import qsbs_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // restoring divide of unsigned magnitudes, one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: design/quant_step_bisection_search_top.sv
// Bisection quantizer step search over one block of signed Q16.16 coefficients.
// Input channel: in_valid / in_stall carry coefficient and last_coefficient. A
// coefficient is taken whenever in_valid is high while loading; the transfer with
// last_coefficient set closes the block and starts the search.
// During the search and emission in_stall stays high.
// Search: one pass over the stored coefficients for the positive maximum,
// then each bisection pass divides every coefficient through one shared
// restoring divider. The number of passes is at most max_iterations,
// clamped to the range 1 to 64.
// Output channel: out_valid / out_stall carry one result per stored coefficient,
// in store order; emission recomputes each codeword with the same divider,
// starting each division only once the previous result has been or is being taken.
// A stalled result holds in the output register until taken.
// Configuration: cfg_we, cfg_index, cfg_data write a register, to be used only
// while the block is idle.
// Reset (rst_n low, asynchronous) empties the block and restores the register
// defaults; no clearing pass is needed.
module quant_step_bisection_search_top #(
    parameter int unsigned N_COEFS   = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  qsbs_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output qsbs_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [qsbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qsbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import qsbs_pkg::*;

    localparam int unsigned AW = $clog2(N_COEFS);
    localparam int unsigned CW = $clog2(N_COEFS + 1);

    state_t state_reg, state_next;

    logic [21:0] target_reg, tol_reg;
    logic [6:0]  max_iter_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   step_reg, step_next;
    logic [31:0]   low_reg, low_next;
    logic [31:0]   high_reg, high_next;
    logic [31:0]   used_reg, used_next;
    logic [6:0]    pass_reg, pass_next;
    logic signed [31:0] maxpos_reg, maxpos_next;
    logic [31:0]   qmax_reg, qmax_next;
    logic [6:0]    nnz_reg, nnz_next;
    logic [11:0]   total_reg, total_next;
    logic          inside_reg, inside_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg, out_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [AW-1:0] rd_addr_reg;
    logic          rd_ok;
    logic [31:0]   rdata;
    logic signed [31:0] coef_rd;

    div_req_t dreq;
    div_rsp_t drsp;
    logic [31:0] mag;
    logic signed [31:0] code;
    logic [31:0] code_pos;

    logic [6:0]  limit;
    logic [5:0]  bits;
    logic [31:0] qv;
    logic [63:0] lhs, tgt, tol_w;
    logic        inside_w;

    qsbs_ram #(.WIDTH(32), .DEPTH(N_COEFS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_data.coefficient),
        .raddr (raddr),
        .rdata (rdata)
    );

    qsbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign coef_rd  = signed'(rdata);
    assign in_stall = (state_reg != ST_LOAD);
    assign we       = in_valid && !in_stall && (count_reg < CW'(N_COEFS));
    assign waddr    = count_reg[AW-1:0];
    assign raddr    = idx_reg[AW-1:0];
    assign rd_ok    = (rd_addr_reg == raddr);
    assign mag      = coef_rd[31] ? (32'd0 - rdata) : rdata;
    assign code     = coef_rd[31] ? signed'(32'd0 - drsp.quotient) : signed'(drsp.quotient);
    assign code_pos = code[31] ? 32'd0 : code;

    assign limit = (max_iter_reg == 7'd0) ? 7'd1 :
                   (max_iter_reg > 7'd64) ? 7'd64 : max_iter_reg;

    // bits per nonzero: ceil(log2 qmax) + 1
    always_comb
    begin
        qv   = qmax_reg - 32'd1;
        bits = 6'd1;
        for (int b = 0; b < 32; b++)
        begin
            if (qv[b])
            begin
                bits = 6'(b + 2);
            end
        end
        if (qmax_reg == 32'd0)
        begin
            bits = 6'd1;
        end
    end

    assign lhs      = 64'(total_reg) << FRAC_BITS;
    assign tgt      = 64'(target_reg) * 64'(count_reg);
    assign tol_w    = 64'(tol_reg) * 64'(count_reg);
    assign inside_w = (lhs + tol_w > tgt) && (lhs < tgt + tol_w);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= 22'd66;
            tol_reg      <= 22'd7;
            max_iter_reg <= 7'd51;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_W'(REG_TARGET):    target_reg   <= cfg_data;
                CFG_IDX_W'(REG_TOLERANCE): tol_reg      <= cfg_data;
                CFG_IDX_W'(REG_MAX_ITER):  max_iter_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        used_next      = used_reg;
        pass_next      = pass_reg;
        maxpos_next    = maxpos_reg;
        qmax_next      = qmax_reg;
        nnz_next       = nnz_reg;
        total_next     = total_reg;
        inside_next    = inside_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        dreq.start     = 1'b0;
        dreq.dividend  = mag;
        dreq.divisor   = step_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (we)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (in_data.last_coefficient && (we || count_reg != '0))
                    begin
                        idx_next    = '0;
                        maxpos_next = '0;
                        state_next  = ST_MAX;
                    end
                end
            end
            ST_MAX:
            begin
                // idx leads the registered read data by one entry
                if (idx_reg != '0 && coef_rd > maxpos_reg)
                begin
                    maxpos_next = coef_rd;
                end
                if (idx_reg == count_reg)
                begin
                    state_next = ST_PASS_START;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (idx_reg == count_reg)
                begin
                    if (idx_reg != '0 && coef_rd > maxpos_reg)
                    begin
                        step_next = rdata;
                    end
                    else
                    begin
                        step_next = (maxpos_reg < 1) ? 32'd1 : maxpos_reg;
                    end
                    high_next = step_next;
                    low_next  = 32'd1;
                    pass_next = '0;
                end
            end
            ST_PASS_START:
            begin
                idx_next   = '0;
                nnz_next   = '0;
                qmax_next  = '0;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                // start once the read data belongs to idx
                if (rd_ok)
                begin
                    dreq.start = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (drsp.done)
                begin
                    if (code != 0)
                    begin
                        nnz_next = nnz_reg + 7'd1;
                    end
                    if (code_pos > qmax_reg)
                    begin
                        qmax_next = code_pos;
                    end
                    if (idx_reg + CW'(1) == count_reg)
                    begin
                        state_next = ST_BITS;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_BITS:
            begin
                total_next = 12'(nnz_reg) * 12'(bits);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                used_next = step_reg;
                if (lhs > tgt)
                begin
                    low_next  = step_reg;
                    step_next = 32'((33'(step_reg) + 33'(high_reg)) >> 1);
                end
                else if (lhs < tgt)
                begin
                    high_next = step_reg;
                    step_next = 32'((33'(step_reg) + 33'(low_reg)) >> 1);
                end
                pass_next   = pass_reg + 7'd1;
                inside_next = inside_w;
                if (inside_w || (pass_reg + 7'd1 >= limit))
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_START;
                end
                else
                begin
                    state_next = ST_PASS_START;
                end
            end
            ST_EMIT_START:
            begin
                dreq.divisor = used_reg;
                if (rd_ok && (!out_valid_reg || !out_stall))
                begin
                    dreq.start = 1'b1;
                    state_next = ST_EMIT_DIV;
                end
            end
            ST_EMIT_DIV:
            begin
                dreq.divisor = used_reg;
                if (drsp.done)
                begin
                    out_next.codeword         = code;
                    out_next.coef_index       = 6'(idx_reg);
                    out_next.final_step       = used_reg[30:0];
                    out_next.nonzero_count    = nnz_reg;
                    out_next.total_bits       = total_reg;
                    out_next.passes_used      = pass_reg;
                    out_next.within_tolerance = inside_reg;
                    out_next.last_codeword    = (idx_reg + CW'(1) == count_reg);
                    out_valid_next            = 1'b1;
                    state_next                = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT:
            begin
                if (idx_reg + CW'(1) == count_reg)
                begin
                    count_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_EMIT_START;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // search payload registers
    always_ff @(posedge clk)
    begin
        used_reg    <= used_next;
        maxpos_reg  <= maxpos_next;
        qmax_reg    <= qmax_next;
        nnz_reg     <= nnz_next;
        total_reg   <= total_next;
        inside_reg  <= inside_next;
        out_reg     <= out_next;
        rd_addr_reg <= raddr;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: design/qsbs_checker.sv
module qsbs_props (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input qsbs_pkg::out_item_t out_data
);
    import qsbs_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an input transfer only meets the final result of a block
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid || out_data.last_codeword)
        else $error("input open while emitting");

    // every step reported is at least one
    a_step_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.final_step != 31'd0)
        else $error("zero step");

    // the pass count is never zero on a result
    a_pass_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.passes_used != 7'd0)
        else $error("zero passes");

endmodule

bind quant_step_bisection_search_top qsbs_props u_qsbs_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: test/qsbs_checker.sv
`timescale 1ns / 100ps

// watches both channels and the register port, predicts every block's codewords
// and compares each output transfer against the oldest prediction
module qsbs_checker #(
    parameter int unsigned N_COEFS   = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  qsbs_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  qsbs_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [qsbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qsbs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import qsbs_pkg::*;

    logic signed [31:0] coef_mem [64];
    longint             coef_cnt;
    longint             target_q;
    longint             tol_q;
    longint             iter_lim;
    out_item_t          codeword_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // bisection over the stored block, pushes one expected codeword per coefficient
    function automatic void quantize_block();
        longint    n, lim, maxpos, step, lo, hi, used, tgt, tolw, lhs;
        longint    nnz, total, qmax, q, v, bpn;
        int        passes;
        bit        in_window;
        longint    codes [64];
        out_item_t r;
        n = coef_cnt;
        lim = iter_lim;
        if (lim < 1) lim = 1;
        if (lim > 64) lim = 64;
        maxpos = 0;
        for (int i = 0; i < n; i++)
            if (longint'(coef_mem[i]) > maxpos) maxpos = coef_mem[i];
        step = (maxpos < 1) ? 1 : maxpos;
        hi = step;
        lo = 1;
        passes = 0;
        tgt = target_q * n;
        tolw = tol_q * n;
        forever
        begin
            qmax = 0;
            nnz = 0;
            for (int i = 0; i < n; i++)
            begin
                q = longint'(coef_mem[i]) / step;
                codes[i] = q;
                if (q != 0) nnz++;
                if (q > qmax) qmax = q;
            end
            if (qmax < 1)
                bpn = 1;
            else
            begin
                v = qmax - 1;
                bpn = 1;
                while (v != 0)
                begin
                    bpn++;
                    v = v >> 1;
                end
            end
            total = nnz * bpn;
            used = step;
            lhs = total << FRAC_BITS;
            if (lhs > tgt)
            begin
                lo = step;
                step = (step + hi) >> 1;
            end
            else if (lhs < tgt)
            begin
                hi = step;
                step = (step + lo) >> 1;
            end
            passes++;
            in_window = (lhs > tgt - tolw) && (lhs < tgt + tolw);
            if (in_window || passes >= lim) break;
        end
        for (int i = 0; i < n; i++)
        begin
            r.codeword         = 32'(codes[i]);
            r.coef_index       = 6'(i);
            r.final_step       = 31'(used);
            r.nonzero_count    = 7'(nnz);
            r.total_bits       = 12'(total);
            r.passes_used      = 7'(passes);
            r.within_tolerance = in_window;
            r.last_codeword    = (i + 1 == n);
            codeword_q.push_back(r);
        end
        coef_cnt = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_cnt = 0;
            target_q = 66;
            tol_q    = 7;
            iter_lim = 51;
            codeword_q.delete();
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_W'(REG_TARGET):    target_q = cfg_data;
                    CFG_IDX_W'(REG_TOLERANCE): tol_q    = cfg_data;
                    CFG_IDX_W'(REG_MAX_ITER):  iter_lim = cfg_data[6:0];
                    default: ;
                endcase
            end
            // coefficient transfer
            if (in_valid && !in_stall)
            begin
                if (coef_cnt < N_COEFS)
                begin
                    coef_mem[coef_cnt] = in_data.coefficient;
                    coef_cnt++;
                end
                if (in_data.last_coefficient && coef_cnt > 0) quantize_block();
            end
            // codeword transfer
            if (out_valid && !out_stall)
            begin
                if (codeword_q.size() == 0)
                begin
                    $display("%0t: unexpected codeword, expected none actual %0d",
                             $time, out_data.codeword);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = codeword_q.pop_front();
                    check_field("codeword", e.codeword, out_data.codeword);
                    check_field("coef_index", e.coef_index, out_data.coef_index);
                    check_field("final_step", e.final_step, out_data.final_step);
                    check_field("nonzero_count", e.nonzero_count, out_data.nonzero_count);
                    check_field("total_bits", e.total_bits, out_data.total_bits);
                    check_field("passes_used", e.passes_used, out_data.passes_used);
                    check_field("within_tolerance", e.within_tolerance,
                                out_data.within_tolerance);
                    check_field("last_codeword", e.last_codeword, out_data.last_codeword);
                end
            end
        end
        pending = codeword_q.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import qsbs_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    errors;
    int                    pending;
    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    int                    items_sent = 0;

    quant_step_bisection_search_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qsbs_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // run limit
    initial
    begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // one coefficient transfer, with random idle cycles ahead of it
    task automatic send_coef(logic signed [31:0] coef, logic last);
        logic acc;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{coefficient: coef, last_coefficient: last};
        items_sent++;
        forever
        begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
            if (acc) break;
        end
    endtask

    // drain all codewords, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(logic [21:0] tgt, logic [21:0] tol, logic [21:0] iter);
        cfg_we <= 1'b1; cfg_index <= CFG_IDX_W'(REG_TARGET);    cfg_data <= tgt;
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= CFG_IDX_W'(REG_TOLERANCE); cfg_data <= tol;
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= CFG_IDX_W'(REG_MAX_ITER);  cfg_data <= iter;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_regs();
        logic [21:0] tgt, tol, iter;
        case ($urandom_range(0, 3))
            0: tgt = 22'd1;
            1: tgt = 22'd2097152;
            2: tgt = 22'($urandom_range(1, 2097152));
            default: tgt = 22'($urandom_range(1, 8) * 65536 / $urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 3))
            0: tol = 22'd0;
            1: tol = 22'd2097152;
            2: tol = 22'($urandom_range(0, 2097152));
            default: tol = tgt >> $urandom_range(0, 4);
        endcase
        case ($urandom_range(0, 5))
            0: iter = 22'd0;
            1: iter = 22'd1;
            2: iter = 22'd64;
            3: iter = 22'd127;
            default: iter = 22'($urandom_range(1, 64));
        endcase
        if ($urandom_range(0, 3) == 0) iter[21:7] = 15'($urandom);
        write_regs(tgt, tol, iter);
    endtask

    function automatic logic signed [31:0] rand_coef();
        logic signed [31:0] c;
        case ($urandom_range(0, 4))
            0: c = $urandom;
            1: c = (32'sd1 <<< $urandom_range(0, 30)) + $urandom_range(0, 255);
            2: c = $urandom_range(0, 262144);
            3: c = $urandom_range(0, 3) == 0 ? 32'sh7fffffff : 32'sh80000000;
            default: c = $urandom_range(0, 2);
        endcase
        if ($urandom_range(0, 1) && c != 32'sh80000000) c = -c;
        return c;
    endfunction

    // one block of random content, the last coefficient closes it
    task automatic send_block(int n, bit all_neg);
        logic signed [31:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = rand_coef();
            if (all_neg && c > 0) c = -c;
            send_coef(c, i == n - 1);
        end
    endtask

    initial
    begin
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes under reset settings
        send_coef(32'sh7fffffff, 1'b1);
        send_coef(32'sh80000000, 1'b0);
        send_coef(-32'sd1, 1'b1);
        send_coef(32'sd0, 1'b0);
        send_coef(32'sd1, 1'b0);
        send_coef(-32'sd65536, 1'b1);
        wait_idle();
        // tightest target, no tolerance, iteration limit of zero
        write_regs(22'd1, 22'd0, 22'd0);
        send_coef(32'sd65536, 1'b0);
        send_coef(32'sd3000000, 1'b0);
        send_coef(-32'sd12345678, 1'b1);
        wait_idle();
        // widest window and an iteration limit above range
        write_regs(22'd2097152, 22'd2097152, 22'd127);
        send_coef(32'sh55555555, 1'b0);
        send_coef(32'shaaaaaaaa, 1'b0);
        send_coef(32'sd7, 1'b1);
        wait_idle();
        write_regs(22'd131072, 22'd0, 22'd64);
        send_coef(32'sd0, 1'b0);
        send_coef(32'sd0, 1'b1);
        wait_idle();

        // random blocks in three idling phases
        for (int p = 0; p < 3; p++)
        begin
            idle_pct  = (p == 0) ? 15 : (p == 1) ? 80 : 0;
            stall_pct = (p == 0) ? 80 : (p == 1) ? 15 : 0;
            while (items_sent < 20 + (p + 1) * 137)
            begin
                wait_idle();
                random_regs();
                repeat (4)
                begin
                    n = $urandom_range(0, 99);
                    if (n < 3)
                        n = $urandom_range(33, 36);
                    else if (n < 10)
                        n = $urandom_range(7, 32);
                    else
                        n = $urandom_range(1, 6);
                    send_block(n, $urandom_range(0, 7) == 0);
                end
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
